// ----- hw/rtl/aslfd_pkg.sv -----
// Package: types and constants shared by the ASCII length frame delimiter.
package aslfd_pkg;

  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_BUFFER_LIMIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_TERM = 1'b1;

  localparam logic [7:0] RESET_BUFFER_LIMIT = 8'd99;
  localparam logic [7:0] HDR_BYTE           = 8'h30;
  localparam logic [7:0] CODE_BIN_BYTE      = 8'h31;
  localparam logic [7:0] CODE_BCD_BYTE      = 8'h32;
  localparam logic [7:0] TERM_MARK_BYTE     = 8'h75;
  localparam logic [7:0] ASCII_NINE         = 8'h39;
  localparam logic [7:0] COUNT_MAX          = 8'hFF;
  localparam logic [2:0] MAX_MISMATCH       = 3'd5;
  localparam logic [2:0] REALIGN_NONE       = 3'd0;
  localparam logic [2:0] REALIGN_TERM       = 3'd4;
  localparam logic [2:0] REALIGN_LEN        = 3'd5;
  localparam logic [7:0] LEN_OFFSET         = 8'd5;

  typedef enum logic [2:0] {
    HS_HEADER   = 3'd0,
    HS_CODING   = 3'd1,
    HS_HUNDREDS = 3'd2,
    HS_TERM     = 3'd3,
    HS_TENS     = 3'd4,
    HS_UNITS    = 3'd5,
    HS_STALLED  = 3'd6
  } hdr_state_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_HEADER = 2'd1,
    ERR_BAD_CODING = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CODING_NONE = 2'd0,
    CODING_BIN  = 2'd1,
    CODING_BCD  = 2'd2
  } coding_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] preset_length;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_count;
    logic       frame_done;
    logic [7:0] frame_length;
    logic [2:0] realign_size;
    logic [1:0] error_code;
    logic [1:0] coding_mode;
    logic       ignored;
  } result_t;

endpackage

// ----- hw/rtl/aslfd_if.sv -----
// Interfaces: request and result channels of the frame delimiter.
interface aslfd_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] preset_length;

  modport source (output valid, output kind, output data_byte, output preset_length,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input preset_length,
                output ready);
endinterface

interface aslfd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_count;
  logic       frame_done;
  logic [7:0] frame_length;
  logic [2:0] realign_size;
  logic [1:0] error_code;
  logic [1:0] coding_mode;
  logic       ignored;

  modport source (output valid, output byte_count, output frame_done, output frame_length,
                  output realign_size, output error_code, output coding_mode,
                  output ignored, input ready);
  modport sink (input valid, input byte_count, input frame_done, input frame_length,
                input realign_size, input error_code, input coding_mode,
                input ignored, output ready);
endinterface

// ----- hw/rtl/aslfd_core.sv -----
// Frame state, header parser and end-of-frame detection for one request per cycle while step_i is high.
module aslfd_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [aslfd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic                                step_i,
  input  aslfd_pkg::item_t                    item_i,
  output aslfd_pkg::result_t                  result_o
);
  import aslfd_pkg::*;

  logic [7:0]  limit_q, dterm_q;
  hdr_state_e  hs_q, hs_d;
  logic [2:0]  mis_q, mis_d;
  logic [9:0]  hund_q, hund_d;
  logic [6:0]  tens_q, tens_d;
  logic [7:0]  hterm_q, hterm_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  err_e        err_q, err_d;
  coding_e     cod_q, cod_d;

  logic [7:0]  marker;
  logic [7:0]  c;
  logic [7:0]  digit;
  logic        is_digit;
  logic [7:0]  cnt_inc;
  logic        end_hit;
  logic [10:0] len_sum;
  logic        done;
  logic [2:0]  realign;
  logic        ign;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= RESET_BUFFER_LIMIT;
      dterm_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BUFFER_LIMIT: limit_q <= cfg_data_i;
        CFG_DEFAULT_TERM: dterm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q    <= HS_HEADER;
      mis_q   <= 3'd0;
      hund_q  <= 10'd0;
      tens_q  <= 7'd0;
      hterm_q <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
      run_q   <= 1'b0;
      err_q   <= ERR_NONE;
      cod_q   <= CODING_NONE;
    end else if (step_i) begin
      hs_q    <= hs_d;
      mis_q   <= mis_d;
      hund_q  <= hund_d;
      tens_q  <= tens_d;
      hterm_q <= hterm_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      err_q   <= err_d;
      cod_q   <= cod_d;
    end
  end

  always_comb begin
    c        = item_i.data_byte;
    marker   = (limit_q == COUNT_MAX) ? COUNT_MAX : limit_q + 8'd1;
    digit    = c - HDR_BYTE;
    is_digit = (c >= HDR_BYTE) && (c <= ASCII_NINE);
    cnt_inc  = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + 8'd1;
    end_hit  = ((len_q == 8'd0) && (c == dterm_q)) ||
               ((len_q == marker) && (c == hterm_q));
    len_sum  = {1'b0, hund_q} + {4'd0, tens_q} + {3'd0, digit} + {3'd0, LEN_OFFSET};

    hs_d    = hs_q;
    mis_d   = mis_q;
    hund_d  = hund_q;
    tens_d  = tens_q;
    hterm_d = hterm_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    err_d   = err_q;
    cod_d   = cod_q;
    done    = 1'b0;
    realign = REALIGN_NONE;
    ign     = 1'b0;

    if (item_i.kind) begin
      len_d = item_i.preset_length;
      cnt_d = 8'd0;
      run_d = 1'b1;
      hs_d  = HS_HEADER;
    end else if (!run_q) begin
      ign = 1'b1;
    end else begin
      cnt_d = cnt_inc;
      if (end_hit) begin
        len_d = cnt_inc;
        hs_d  = HS_HEADER;
      end else if (len_q == 8'd0) begin
        len_d = 8'd0;
        unique case (hs_q)
          HS_HEADER: begin
            if (c == HDR_BYTE) begin
              hs_d  = HS_CODING;
              mis_d = 3'd0;
            end else begin
              err_d = ERR_BAD_HEADER;
              if (mis_q < MAX_MISMATCH) begin
                mis_d = mis_q + 3'd1;
              end else begin
                hs_d  = HS_STALLED;
                mis_d = 3'd0;
              end
            end
          end
          HS_CODING: begin
            if (c == CODE_BIN_BYTE) begin
              cod_d = CODING_BIN;
              hs_d  = HS_HUNDREDS;
            end else if (c == CODE_BCD_BYTE) begin
              cod_d = CODING_BCD;
              hs_d  = HS_HUNDREDS;
            end else begin
              err_d = ERR_BAD_CODING;
              hs_d  = HS_HEADER;
            end
          end
          HS_TERM: begin
            hterm_d = c;
            len_d   = marker;
            hs_d    = HS_HEADER;
            if (cnt_inc > 8'd4) begin
              cnt_d   = 8'd4;
              realign = REALIGN_TERM;
            end
          end
          HS_HUNDREDS: begin
            if (c == TERM_MARK_BYTE) begin
              hs_d = HS_TERM;
            end else if (!is_digit) begin
              hs_d = HS_HEADER;
            end else begin
              hund_d = 10'(digit[3:0]) * 10'd100;
              hs_d   = HS_TENS;
            end
          end
          HS_TENS: begin
            if (!is_digit) begin
              hs_d = HS_HEADER;
            end else begin
              tens_d = 7'(digit[3:0]) * 7'd10;
              hs_d   = HS_UNITS;
            end
          end
          HS_UNITS: begin
            if (is_digit) begin
              len_d = (len_sum > 11'd255) ? COUNT_MAX : len_sum[7:0];
              if (cnt_inc > 8'd5) begin
                cnt_d   = 8'd5;
                realign = REALIGN_LEN;
              end
            end
            hs_d = HS_HEADER;
          end
          default: ;
        endcase
      end
      if ((cnt_d == len_d) || (cnt_d == limit_q)) begin
        done  = 1'b1;
        run_d = 1'b0;
      end
    end

    result_o.byte_count   = cnt_d;
    result_o.frame_done   = done;
    result_o.frame_length = len_d;
    result_o.realign_size = realign;
    result_o.error_code   = err_d;
    result_o.coding_mode  = cod_d;
    result_o.ignored      = ign;
  end

endmodule

// ----- hw/rtl/ascii_length_frame_delimiter.sv -----
// Top level: ASCII length frame delimiter with request and result registers.
//
//   channel  dir  payload
//   req_i    in   kind, data_byte, preset_length
//   rsp_o    out  byte_count, frame_done, frame_length, realign_size,
//                 error_code, coding_mode, ignored
//   cfg_*    in   buffer_limit (index 0), default_terminator (index 1)
//
// One request per cycle while the result is not stalled.
// The request register feeds the frame state update, which loads the result register.
// A stalled result holds; the request register keeps accepting while the result moves.
// Reset returns all frame state to idle, waiting for a header, limit 99.
module ascii_length_frame_delimiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aslfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  aslfd_req_if.sink                     req_i,
  aslfd_rsp_if.source                   rsp_o
);
  import aslfd_pkg::*;

  logic    in_vld_q, in_vld_d;
  item_t   item_q;
  logic    out_vld_q, out_vld_d;
  result_t res_q;
  result_t res_d;
  logic    advance;
  logic    req_take;

  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign req_take    = req_i.valid && req_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (req_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      item_q.kind          <= req_i.kind;
      item_q.data_byte     <= req_i.data_byte;
      item_q.preset_length <= req_i.preset_length;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  aslfd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .item_i     (item_q),
    .result_o   (res_d)
  );

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.byte_count   = res_q.byte_count;
  assign rsp_o.frame_done   = res_q.frame_done;
  assign rsp_o.frame_length = res_q.frame_length;
  assign rsp_o.realign_size = res_q.realign_size;
  assign rsp_o.error_code   = res_q.error_code;
  assign rsp_o.coding_mode  = res_q.coding_mode;
  assign rsp_o.ignored      = res_q.ignored;

endmodule
